FILE: hdl/ctk_pkg.sv
// Shared types, codes and the genetic-code table for the codon translation window.
`timescale 1ns / 1ps
package ctk_pkg;

	localparam logic [2:0] BASE_N   = 3'd4;
	localparam logic [2:0] BASE_GAP = 3'd5;

	localparam logic [4:0] AA_ZERO    = 5'd0;
	localparam logic [4:0] AA_UNKNOWN = 5'd21;
	localparam logic [4:0] AA_EMPTY   = 5'd22;

	localparam logic signed [31:0] NO_POS = -32'sd1;

	typedef enum logic [1:0] {
		KIND_WINDOW    = 2'd0,
		KIND_REMAIN    = 2'd1,
		KIND_ORDER_ERR = 2'd2
	} kind_t;

	typedef struct packed {
		logic              func;
		logic [2:0]        base;
		logic signed [31:0] ref_pos;
		logic              interesting;
	} sym_t;

	typedef struct packed {
		kind_t             kind;
		logic [4:0]        amino_acid;
		logic signed [31:0] first_pos;
		logic signed [31:0] last_pos;
		logic              marked;
		logic              last;
	} res_t;

	// one stored codon
	typedef struct packed {
		logic [4:0]         aa;
		logic signed [31:0] first;
		logic signed [31:0] last;
		logic               mark;
	} entry_t;

	// standard genetic code, index {b1, b2, b3} with bases A C G T
	localparam logic [4:0] CODE_TABLE [0:63] = '{
		5'd8,  5'd11, 5'd8,  5'd11, 5'd16, 5'd16, 5'd16, 5'd16,
		5'd14, 5'd15, 5'd14, 5'd15, 5'd7,  5'd7,  5'd10, 5'd7,
		5'd13, 5'd6,  5'd13, 5'd6,  5'd12, 5'd12, 5'd12, 5'd12,
		5'd14, 5'd14, 5'd14, 5'd14, 5'd9,  5'd9,  5'd9,  5'd9,
		5'd3,  5'd2,  5'd3,  5'd2,  5'd0,  5'd0,  5'd0,  5'd0,
		5'd5,  5'd5,  5'd5,  5'd5,  5'd17, 5'd17, 5'd17, 5'd17,
		5'd20, 5'd19, 5'd20, 5'd19, 5'd15, 5'd15, 5'd15, 5'd15,
		5'd20, 5'd1,  5'd18, 5'd1,  5'd9,  5'd4,  5'd9,  5'd4
	};

endpackage

FILE: hdl/ctk_stream_if.sv
// Valid/ready stream channel carrying one payload word.
`timescale 1ns / 1ps
interface ctk_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/codon_translate_kmer_window.sv
// Codon translation with a sliding amino-acid window, top level.
//
// sym carries one aligned nucleotide word per beat: a base or gap with its
// reference coordinate and interesting flag, or an end-of-transcript flush.
// Every third real base completes a codon, which is translated and stored.
// When the store holds WINDOW_LEN codons the whole window goes out on res
// as WINDOW_LEN words (last on the final one) and the oldest codon drops.
// A flush sends the remainder (or one empty word) and clears the block.
// A coordinate that does not increase within the pending codon gives one
// order-error word and the symbol is dropped.
//
// Results appear on res in the cycle after the symbol is taken and leave
// one word per cycle while res is ready. Symbols that give no result go at
// one per cycle while no run is pending; a symbol that releases a run
// holds the run buffer until all its words (up to WINDOW_LEN) have left,
// so sustained throughput is set by the one-word-per-cycle result port.
// sym is taken again in the cycle the final word of a run leaves.
// Reset empties the pending codon, the store and the run buffer. While res
// stalls, the run holds and sym takes only words after the run is drained.
`timescale 1ns / 1ps
module codon_translate_kmer_window
	import ctk_pkg::*;
#(
	parameter int WINDOW_LEN = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	ctk_stream_if.sink          sym,
	ctk_stream_if.source        res
);

	localparam int FW = $clog2(WINDOW_LEN + 1);
	localparam logic [FW-1:0] FILL_TOP = FW'(WINDOW_LEN - 1);
	localparam logic [FW-1:0] RUN_FULL = FW'(WINDOW_LEN);
	localparam logic [FW-1:0] ONE      = FW'(1);

	// pending codon
	logic [5:0]         pend_bases_q;
	logic [1:0]         pend_cnt_q;
	logic signed [31:0] pend_first_q;
	logic signed [31:0] pend_last_q;
	logic               pend_mark_q;
	logic signed [31:0] ord_pos_q;
	logic               ord_valid_q;

	// codon store and run buffer
	entry_t             win_q [WINDOW_LEN];
	logic [FW-1:0]      fill_q;
	entry_t             run_q [WINDOW_LEN];
	logic [FW-1:0]      run_cnt_q;
	kind_t              run_kind_q;

	sym_t               d;
	logic               accept;
	logic               take;
	logic               pos_none;
	logic               order_err;
	logic [2:0]         base_n;
	logic               is_gap;
	logic signed [31:0] first_nx;
	logic signed [31:0] last_nx;
	logic               mark_nx;
	logic               codon_done;
	logic               win_full;
	logic [2:0]         b1;
	logic [2:0]         b2;
	logic [4:0]         aa;
	entry_t             new_e;
	entry_t             snap [WINDOW_LEN];
	logic               load;

	assign d      = sym.data;
	assign take   = res.valid && res.ready;
	assign accept = sym.valid && sym.ready;

	assign sym.ready = (run_cnt_q == '0) || (res.ready && run_cnt_q == ONE);

	always_comb begin
		pos_none   = (d.ref_pos == NO_POS);
		order_err  = !d.func && !pos_none && ord_valid_q && (d.ref_pos <= ord_pos_q);
		base_n     = (d.base > BASE_GAP) ? BASE_N : d.base;
		is_gap     = (base_n == BASE_GAP);
		first_nx   = (!pos_none && pend_first_q == NO_POS) ? d.ref_pos : pend_first_q;
		last_nx    = pos_none ? pend_last_q : d.ref_pos;
		mark_nx    = pend_mark_q | d.interesting;
		codon_done = !d.func && !order_err && !is_gap && (pend_cnt_q == 2'd2);
		win_full   = codon_done && (fill_q == FILL_TOP);
		b1         = pend_bases_q[2:0];
		b2         = pend_bases_q[5:3];
		// any N in the codon makes it unknown
		if (b1[2] || b2[2] || base_n[2]) begin
			aa = AA_UNKNOWN;
		end else begin
			aa = CODE_TABLE[{b1[1:0], b2[1:0], base_n[1:0]}];
		end
		new_e.aa    = aa;
		new_e.first = first_nx;
		new_e.last  = last_nx;
		new_e.mark  = mark_nx;
		// window as it stands once the completing codon is in the top slot
		for (int i = 0; i < WINDOW_LEN; i++) begin
			snap[i] = (i == WINDOW_LEN - 1) ? new_e : win_q[i];
		end
		load = accept && (d.func || order_err || win_full);
	end

	// pending codon and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bases_q <= '0;
			pend_cnt_q   <= '0;
			pend_first_q <= NO_POS;
			pend_last_q  <= NO_POS;
			pend_mark_q  <= 1'b0;
			ord_pos_q    <= '0;
			ord_valid_q  <= 1'b0;
			fill_q       <= '0;
		end else if (accept) begin
			if (d.func || codon_done) begin
				pend_bases_q <= '0;
				pend_cnt_q   <= '0;
				pend_first_q <= NO_POS;
				pend_last_q  <= NO_POS;
				pend_mark_q  <= 1'b0;
				ord_pos_q    <= '0;
				ord_valid_q  <= 1'b0;
				if (d.func) begin
					fill_q <= '0;
				end else begin
					fill_q <= win_full ? FILL_TOP : fill_q + ONE;
				end
			end else if (!order_err) begin
				if (!pos_none) begin
					ord_pos_q   <= d.ref_pos;
					ord_valid_q <= 1'b1;
				end
				pend_mark_q <= mark_nx;
				if (!is_gap) begin
					pend_first_q <= first_nx;
					pend_last_q  <= last_nx;
					pend_cnt_q   <= pend_cnt_q + 2'd1;
					if (pend_cnt_q == 2'd0) begin
						pend_bases_q[2:0] <= base_n;
					end else begin
						pend_bases_q[5:3] <= base_n;
					end
				end
			end
		end
	end

	// codon store: write at the fill point, or drop the oldest when full
	always_ff @(posedge clk) begin
		if (accept && codon_done) begin
			if (win_full) begin
				for (int i = 0; i < WINDOW_LEN - 1; i++) begin
					win_q[i] <= snap[i + 1];
				end
			end else begin
				for (int i = 0; i < WINDOW_LEN; i++) begin
					if (FW'(i) == fill_q) begin
						win_q[i] <= new_e;
					end
				end
			end
		end
	end

	// run buffer count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_cnt_q <= '0;
		end else if (load) begin
			if (d.func) begin
				run_cnt_q <= (fill_q == '0) ? ONE : fill_q;
			end else if (order_err) begin
				run_cnt_q <= ONE;
			end else begin
				run_cnt_q <= RUN_FULL;
			end
		end else if (take) begin
			run_cnt_q <= run_cnt_q - ONE;
		end
	end

	// run buffer words: load a run, advance one word per beat taken
	always_ff @(posedge clk) begin
		if (load) begin
			if (d.func) begin
				run_kind_q <= KIND_REMAIN;
				if (fill_q == '0) begin
					run_q[0] <= '{aa: AA_EMPTY, first: NO_POS, last: NO_POS, mark: 1'b0};
				end else begin
					run_q <= win_q;
				end
			end else if (order_err) begin
				run_kind_q <= KIND_ORDER_ERR;
				run_q[0]   <= '{aa: AA_ZERO, first: d.ref_pos, last: ord_pos_q, mark: 1'b0};
			end else begin
				run_kind_q <= KIND_WINDOW;
				run_q      <= snap;
			end
		end else if (take) begin
			for (int i = 0; i < WINDOW_LEN - 1; i++) begin
				run_q[i] <= run_q[i + 1];
			end
		end
	end

	assign res.valid           = (run_cnt_q != '0);
	assign res.data.kind       = run_kind_q;
	assign res.data.amino_acid = run_q[0].aa;
	assign res.data.first_pos  = run_q[0].first;
	assign res.data.last_pos   = run_q[0].last;
	assign res.data.marked     = run_q[0].mark;
	assign res.data.last       = (run_cnt_q == ONE);

endmodule

FILE: hdl/ctk_checker.sv
// Port-level assertions for the codon translation window, bound to the top level.
`timescale 1ns / 1ps
module ctk_checker
	import ctk_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       sym_valid,
	input logic       sym_ready,
	input logic       sym_func,
	input logic       res_valid,
	input logic       res_ready,
	input logic       res_last,
	input logic [1:0] res_kind
);

	// hold a stalled result word
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word dropped while stalled");

	// an order error is always a run of one word
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == KIND_ORDER_ERR |-> res_last)
		else $error("order error word without last");

	// a flush always yields at least one result word
	a_flush_out: assert property (@(posedge clk) disable iff (!arst_n)
		sym_valid && sym_ready && sym_func |=> res_valid)
		else $error("flush produced no result");

	// a new symbol is taken during a run only as its final word leaves
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		sym_valid && sym_ready && res_valid |-> res_ready && res_last)
		else $error("symbol taken while run still pending");

endmodule

bind codon_translate_kmer_window ctk_checker u_ctk_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.sym_valid (sym.valid),
	.sym_ready (sym.ready),
	.sym_func  (sym.data.func),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_last  (res.data.last),
	.res_kind  (res.data.kind)
);
